>>> rtl/core/sitrd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitrd_pkg
// Shared types, constants and helpers for the radix digit converter.
// ---------------------------------------------------------------------------
package sitrd_pkg;

    localparam int VALUE_PORT_W = 64;
    localparam int RADIX_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 7;
    localparam int CHUNK_BITS   = 8;

    typedef logic [RADIX_W-1:0] t_radix;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_radix RADIX_RESET = 5'd10;
    localparam t_radix RADIX_MIN   = 5'd2;
    localparam t_radix RADIX_MAX   = 5'd16;
    localparam t_digit DIGIT_TEN   = 4'd10;
    localparam t_char  ASCII_ZERO  = 7'h30;
    localparam t_char  ASCII_A     = 7'h41;

    function automatic t_radix eff_radix(input t_radix r);
        t_radix res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic t_char ascii_of(input t_digit d);
        t_char res;
        if (d < DIGIT_TEN) begin
            res = ASCII_ZERO + t_char'(d);
        end else begin
            res = ASCII_A + t_char'(d - DIGIT_TEN);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sitrd_div_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitrd_div_step
// Restoring division by the radix over one chunk of dividend bits.
// ---------------------------------------------------------------------------
module sitrd_div_step (
    input  wire logic [sitrd_pkg::DIGIT_W-1:0]    i_rem,
    input  wire logic [sitrd_pkg::CHUNK_BITS-1:0] i_bits,
    input  wire logic [sitrd_pkg::RADIX_W-1:0]    i_base,
    output logic      [sitrd_pkg::CHUNK_BITS-1:0] o_quo,
    output logic      [sitrd_pkg::DIGIT_W-1:0]    o_rem
);

    logic [sitrd_pkg::RADIX_W-1:0] acc;

    always_comb begin
        acc   = {1'b0, i_rem};
        o_quo = '0;
        for (int i = sitrd_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
            acc = {acc[sitrd_pkg::DIGIT_W-1:0], i_bits[i]};
            if (acc >= i_base) begin
                acc      = acc - i_base;
                o_quo[i] = 1'b1;
            end
        end
        o_rem = acc[sitrd_pkg::DIGIT_W-1:0];
    end

endmodule
`default_nettype wire

>>> rtl/core/signed_integer_to_radix_digits_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// signed_integer_to_radix_digits_core
// Converts a signed integer to ASCII digits in radix 2..16, MSD first.
// ---------------------------------------------------------------------------
// Each digit is found by running the shared 8-bit divide step over every 8-bit chunk
// of the value, top chunk first. The digits are then strobed MSD first, one digit per
// cycle; busy is high while dividing and emitting, and is low when the last is strobed.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous active-low reset; radix resets to 10.
module signed_integer_to_radix_digits_core #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sitrd_pkg::VALUE_PORT_W-1:0] i_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [sitrd_pkg::RADIX_W-1:0]      i_cfg_wdata,
    output logic                                    o_valid,
    output logic      [sitrd_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                                    o_is_negative,
    output logic                                    o_last
);

    localparam int CB    = sitrd_pkg::CHUNK_BITS;
    localparam int QW    = ((VALUE_WIDTH + CB - 1) / CB) * CB;
    localparam int NSTEP = QW / CB;
    localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam int IW    = $clog2(MAX_DIGITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [sitrd_pkg::RADIX_W-1:0] r_radix;
    logic [QW-1:0]              r_quo, n_quo;
    sitrd_pkg::t_digit          r_rem, n_rem;
    logic [SCW-1:0]             r_step, n_step;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [IW-1:0]              r_idx, n_idx;
    logic                       r_sign, n_sign;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_neg, n_out_neg;
    logic                       r_out_last, n_out_last;
    sitrd_pkg::t_digit          r_rd_data;
    logic                       mem_we;

    sitrd_pkg::t_digit          mem [MAX_DIGITS];

    logic [VALUE_WIDTH-1:0]     in_v;
    logic [VALUE_WIDTH-1:0]     in_mag;
    logic [sitrd_pkg::RADIX_W-1:0] base;
    logic [CB-1:0]              step_quo;
    sitrd_pkg::t_digit          step_rem;
    logic [QW-1:0]              quo_shift;

    assign in_v   = i_value[VALUE_WIDTH-1:0];
    assign in_mag = in_v[VALUE_WIDTH-1] ? (~in_v + 1'b1) : in_v;
    assign base   = sitrd_pkg::eff_radix(r_radix);

    sitrd_div_step u_div (
        .i_rem  (r_rem),
        .i_bits (r_quo[QW-1 -: CB]),
        .i_base (base),
        .o_quo  (step_quo),
        .o_rem  (step_rem)
    );

    assign quo_shift = (r_quo << CB) | QW'(step_quo);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_sign      = r_sign;
        n_out_valid = 1'b0;
        n_out_neg   = r_out_neg;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                    n_quo   = QW'(in_mag);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_sign  = in_v[VALUE_WIDTH-1];
                end
            end
            S_DIV: begin
                n_quo = quo_shift;
                n_rem = step_rem;
                if (r_step == SCW'(NSTEP - 1)) begin
                    mem_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_step = '0;
                    n_rem  = '0;
                    if (quo_shift == '0 || r_cnt == CW'(MAX_DIGITS - 1)) begin
                        n_state = S_EMIT;
                        n_idx   = r_cnt[IW-1:0];
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_neg   = r_sign;
                n_out_last  = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= sitrd_pkg::RADIX_RESET;
            r_cnt       <= '0;
            r_step      <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_out_neg  <= n_out_neg;
        r_out_last <= n_out_last;
    end

    // digit store: LSD at index 0
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[IW-1:0]] <= step_rem;
        end
        r_rd_data <= mem[r_idx];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_digit_char  = sitrd_pkg::ascii_of(r_rd_data);
    assign o_is_negative = r_out_neg;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

>>> rtl/core/sitrd_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitrd_checker
// Port-level checks on the digit converter result stream.
// ---------------------------------------------------------------------------
module sitrd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [sitrd_pkg::CHAR_W-1:0]  o_digit_char,
    input wire logic                          o_is_negative,
    input wire logic                          o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    a_run_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("digit run broken before last");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("digit strobe after last");

    a_sign_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_is_negative == $past(o_is_negative)))
        else $error("sign flag changed within a run");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= 7'h30 && o_digit_char <= 7'h39) ||
                     (o_digit_char >= 7'h41 && o_digit_char <= 7'h46)))
        else $error("digit character out of range");

endmodule

bind signed_integer_to_radix_digits_core sitrd_checker u_sitrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_digit_char  (o_digit_char),
    .o_is_negative (o_is_negative),
    .o_last        (o_last)
);
`default_nettype wire
